[hdl/smt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

   // Request operations, carried on req_tuser
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_STARTUP = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // Schedule entry kinds
   localparam logic [2:0] KIND_STARTUP    = 3'd0;
   localparam logic [2:0] KIND_EVERY_MIN  = 3'd1;
   localparam logic [2:0] KIND_EVERY_HOUR = 3'd2;
   localparam logic [2:0] KIND_DAILY      = 3'd3;
   localparam logic [2:0] KIND_WEEKLY     = 3'd4;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_SERVED  = 2'd3;

   // Clock field limits
   localparam logic [5:0] MINUTE_MAX  = 6'd59;
   localparam logic [4:0] HOUR_MAX    = 5'd23;
   localparam logic [2:0] WEEKDAY_MAX = 3'd6;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int MASK_W     = 32;

   // One stored schedule entry
   typedef struct packed {
      logic [2:0] weekday;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [5:0] period;
      logic [2:0] kind;
   } entry_type;

   // Request word layout, lowest field last
   typedef struct packed {
      logic [2:0] pad;
      logic [2:0] now_weekday;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [2:0] entry_weekday;
      logic [5:0] entry_minute;
      logic [4:0] entry_hour;
      logic [5:0] entry_period;
      logic [2:0] entry_kind;
   } req_data_type;

   // Response word layout, lowest field last
   typedef struct packed {
      logic [5:0]  job_count;
      logic [1:0]  status;
      logic [31:0] due_mask;
   } rsp_data_type;

endpackage

`default_nettype wire

[hdl/schedule_match_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Clear, append and an already served tick go straight to the finish step, which loads the response.
// Startup and tick walk the table one entry at a time through scan and load (at most 32 entries),
// and each entry whose modulo runs 6 quotient bits in the shared divider adds the divide and check steps.
// One request at a time: ready again once its response is loaded into the output register;
// a waiting response holds the next request in its last step.
// Synchronous reset empties the table and marks no minute as served; entries keep old data.
module schedule_match_table_top #(
   parameter int MAX_JOBS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // opcode[1:0]
   input  logic [1:0]                     req_tuser,
   // entry_kind[2:0], entry_period[8:3], entry_hour[13:9], entry_minute[19:14],
   // entry_weekday[22:20], now_minute[28:23], now_hour[33:29], now_weekday[36:34]
   input  logic [smt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // due_mask[31:0], status[33:32], job_count[39:34]
   output logic [smt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import smt_pkg::*;

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);
   localparam logic [2:0] DIV_LAST = 3'd5;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   entry_type job_mem [MAX_JOBS];

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [6:0]        last_ff, last_in;
   logic [1:0]        op_ff, op_in;
   logic [5:0]        now_min_ff, now_min_in;
   logic [4:0]        now_hour_ff, now_hour_in;
   logic [2:0]        now_wd_ff, now_wd_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [MASK_W-1:0] bit_ff, bit_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [1:0]        status_ff, status_in;
   logic [5:0]        dvd_ff, dvd_in;
   logic [5:0]        rem_ff, rem_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;
   entry_type         rd_data_ff;

   req_data_type req_d;
   entry_type    new_entry;
   logic         entry_ok;
   logic         mem_we;
   logic [6:0]   trial;
   logic [5:0]   rem_next;
   logic         load_hit;
   logic         load_div;

   assign req_d      = req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // Check and pack an appended entry, zeroing the fields its kind ignores
   always_comb begin
      new_entry      = '0;
      new_entry.kind = req_d.entry_kind;
      entry_ok       = 1'b0;
      case (req_d.entry_kind)
         KIND_STARTUP: begin
            entry_ok = 1'b1;
         end
         KIND_EVERY_MIN: begin
            entry_ok         = (req_d.entry_period != '0) && (req_d.entry_period <= MINUTE_MAX);
            new_entry.period = req_d.entry_period;
         end
         KIND_EVERY_HOUR: begin
            entry_ok         = (req_d.entry_period != '0)
                               && (req_d.entry_period <= 6'(HOUR_MAX));
            new_entry.period = req_d.entry_period;
         end
         KIND_DAILY: begin
            entry_ok         = (req_d.entry_hour <= HOUR_MAX) && (req_d.entry_minute <= MINUTE_MAX);
            new_entry.hour   = req_d.entry_hour;
            new_entry.minute = req_d.entry_minute;
         end
         KIND_WEEKLY: begin
            entry_ok          = (req_d.entry_hour <= HOUR_MAX) && (req_d.entry_minute <= MINUTE_MAX)
                                && (req_d.entry_weekday <= WEEKDAY_MAX);
            new_entry.hour    = req_d.entry_hour;
            new_entry.minute  = req_d.entry_minute;
            new_entry.weekday = req_d.entry_weekday;
         end
         default: begin
            entry_ok = 1'b0;
         end
      endcase
   end

   // One restoring division step: shift in a dividend bit, subtract if it fits
   assign trial    = {rem_ff, dvd_ff[5]};
   assign rem_next = (trial >= {1'b0, rd_data_ff.period})
                     ? 6'(trial - {1'b0, rd_data_ff.period}) : trial[5:0];

   // Decode the entry just read: direct hit, or hand the modulo to the divider
   always_comb begin
      load_hit = 1'b0;
      load_div = 1'b0;
      if (op_ff == OP_STARTUP) begin
         load_hit = (rd_data_ff.kind == KIND_STARTUP);
      end else begin
         case (rd_data_ff.kind)
            KIND_EVERY_MIN: begin
               load_div = (rd_data_ff.period != '0);
            end
            KIND_EVERY_HOUR: begin
               load_div = (rd_data_ff.period != '0) && (now_min_ff == '0);
            end
            KIND_DAILY: begin
               load_hit = (now_hour_ff == rd_data_ff.hour) && (now_min_ff == rd_data_ff.minute);
            end
            KIND_WEEKLY: begin
               load_hit = (now_wd_ff == rd_data_ff.weekday) && (now_hour_ff == rd_data_ff.hour)
                          && (now_min_ff == rd_data_ff.minute);
            end
            default: begin
               load_hit = 1'b0;
            end
         endcase
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      now_min_in   = now_min_ff;
      now_hour_in  = now_hour_ff;
      now_wd_in    = now_wd_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               now_min_in  = req_d.now_minute;
               now_hour_in = req_d.now_hour;
               now_wd_in   = req_d.now_weekday;
               idx_in      = '0;
               bit_in      = MASK_W'(1);
               mask_in     = '0;
               status_in   = ST_OK;
               state_in    = S_FIN;
               case (req_tuser)
                  OP_CLEAR: begin
                     total_in = '0;
                  end
                  OP_APPEND: begin
                     if (!entry_ok) begin
                        status_in = ST_INVALID;
                     end else if (total_ff >= MAX_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                  end
                  OP_STARTUP: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     if ({1'b0, req_d.now_minute} == last_ff) begin
                        status_in = ST_SERVED;
                     end else begin
                        last_in  = {1'b0, req_d.now_minute};
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // stop at the entry count or after the last reportable entry
            if ((idx_ff >= total_ff) || (bit_ff == '0)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (load_div) begin
               dvd_in   = (rd_data_ff.kind == KIND_EVERY_MIN) ? now_min_ff : {1'b0, now_hour_ff};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               mask_in  = load_hit ? (mask_ff | bit_ff) : mask_ff;
               idx_in   = idx_ff + 1'b1;
               bit_in   = bit_ff << 1;
               state_in = S_SCAN;
            end
         end
         S_DIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            mask_in  = (rem_ff == '0) ? (mask_ff | bit_ff) : mask_ff;
            idx_in   = idx_ff + 1'b1;
            bit_in   = bit_ff << 1;
            state_in = S_SCAN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.due_mask  = mask_ff;
               rsp_data_in.status    = status_ff;
               rsp_data_in.job_count = 6'(total_ff);
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         last_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_min_ff  <= now_min_in;
      now_hour_ff <= now_hour_in;
      now_wd_ff   <= now_wd_in;
      idx_ff      <= idx_in;
      bit_ff      <= bit_in;
      mask_ff     <= mask_in;
      status_ff   <= status_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Entry table: append at the count, read the entry under scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[total_ff[IDX_W-1:0]] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         rd_data_ff <= job_mem[idx_ff[IDX_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_total_bound : assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_CNT)
      else $error("entry count beyond table size");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_CLEAR)) |=> (total_ff == '0))
      else $error("clear did not empty the table");

   a_scan_onehot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD || state_ff == S_DIV || state_ff == S_CHK) |-> $onehot(bit_ff))
      else $error("scan position lost");

   a_mask_behind_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ((mask_ff & ~(bit_ff - MASK_W'(1))) == '0))
      else $error("due bit set ahead of scan position");

   a_div_steps : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= DIV_LAST))
      else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

[dv/tb_schedule_match_table_top.sv]
`timescale 1ns / 1ps

module tb_schedule_match_table_top;
   import smt_pkg::*;

   localparam int TABLE_DEPTH    = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = OP_CLEAR;
   req_data_type req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted table state
   entry_type    sched_table [TABLE_DEPTH];
   int           sched_count = 0;
   logic [6:0]   served_minute = 7'h7f;

   rsp_data_type due_rsp_q [$];
   int           items_sent = 0;
   int           fail_count = 0;
   int           idle_cycles = 0;
   int           send_idle_pct = 17;
   int           recv_idle_pct = 87;

   // wall clock walked by the random schedules
   int           wall_minute = 0;
   int           wall_hour = 0;
   int           wall_wday = 0;

   schedule_match_table_top #(
      .MAX_JOBS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the predicted table by one request word and return its response
   function automatic rsp_data_type apply_request(input logic [1:0] op,
                                                  input req_data_type d);
      rsp_data_type r;
      entry_type    e;
      logic         entry_ok;
      logic         fires;
      r = '0;
      e = '0;
      entry_ok = 1'b0;
      case (op)
         OP_CLEAR: begin
            sched_count = 0;
         end
         OP_APPEND: begin
            // keep only the fields that the kind uses
            e.kind = d.entry_kind;
            case (d.entry_kind)
               KIND_STARTUP: entry_ok = 1'b1;
               KIND_EVERY_MIN: begin
                  entry_ok = d.entry_period >= 6'd1 && d.entry_period <= MINUTE_MAX;
                  e.period = d.entry_period;
               end
               KIND_EVERY_HOUR: begin
                  entry_ok = d.entry_period >= 6'd1 && d.entry_period <= 6'(HOUR_MAX);
                  e.period = d.entry_period;
               end
               KIND_DAILY: begin
                  entry_ok = d.entry_hour <= HOUR_MAX && d.entry_minute <= MINUTE_MAX;
                  e.hour   = d.entry_hour;
                  e.minute = d.entry_minute;
               end
               KIND_WEEKLY: begin
                  entry_ok = d.entry_hour <= HOUR_MAX && d.entry_minute <= MINUTE_MAX &&
                             d.entry_weekday <= WEEKDAY_MAX;
                  e.hour    = d.entry_hour;
                  e.minute  = d.entry_minute;
                  e.weekday = d.entry_weekday;
               end
               default: entry_ok = 1'b0;
            endcase
            // a bad entry is refused as invalid even on a full table
            if (!entry_ok) begin
               r.status = ST_INVALID;
            end else if (sched_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               sched_table[sched_count] = e;
               sched_count++;
            end
         end
         OP_STARTUP: begin
            for (int i = 0; i < sched_count; i++)
               if (sched_table[i].kind == KIND_STARTUP) r.due_mask[i] = 1'b1;
         end
         default: begin
            // only the minute decides whether the tick was already served
            if ({1'b0, d.now_minute} == served_minute) begin
               r.status = ST_SERVED;
            end else begin
               served_minute = {1'b0, d.now_minute};
               for (int i = 0; i < sched_count; i++) begin
                  e = sched_table[i];
                  case (e.kind)
                     KIND_EVERY_MIN:
                        fires = (d.now_minute % e.period) == 6'd0;
                     KIND_EVERY_HOUR:
                        fires = (d.now_hour % e.period) == 6'd0 && d.now_minute == 6'd0;
                     KIND_DAILY:
                        fires = d.now_hour == e.hour && d.now_minute == e.minute;
                     KIND_WEEKLY:
                        fires = d.now_weekday == e.weekday && d.now_hour == e.hour &&
                                d.now_minute == e.minute;
                     default: fires = 1'b0;
                  endcase
                  r.due_mask[i] = fires;
               end
            end
         end
      endcase
      r.job_count = 6'(sched_count);
      return r;
   endfunction

   function automatic req_data_type entry_word(input logic [2:0] kind,
                                               input logic [5:0] period,
                                               input logic [4:0] hour,
                                               input logic [5:0] minute,
                                               input logic [2:0] weekday);
      req_data_type d;
      d = '0;
      d.entry_kind    = kind;
      d.entry_period  = period;
      d.entry_hour    = hour;
      d.entry_minute  = minute;
      d.entry_weekday = weekday;
      return d;
   endfunction

   function automatic req_data_type clock_word(input logic [5:0] minute,
                                               input logic [4:0] hour,
                                               input logic [2:0] weekday);
      req_data_type d;
      d = '0;
      d.now_minute  = minute;
      d.now_hour    = hour;
      d.now_weekday = weekday;
      return d;
   endfunction

   function automatic req_data_type random_word();
      req_data_type d;
      d = '0;
      d.entry_kind    = 3'($urandom_range(7));
      d.entry_period  = 6'($urandom_range(63));
      d.entry_hour    = 5'($urandom_range(31));
      d.entry_minute  = 6'($urandom_range(63));
      d.entry_weekday = 3'($urandom_range(7));
      d.now_minute    = 6'($urandom_range(63));
      d.now_hour      = 5'($urandom_range(31));
      d.now_weekday   = 3'($urandom_range(7));
      return d;
   endfunction

   // Drive one request word from a falling edge and hold it until taken
   task automatic send_request(input logic [1:0] op, input req_data_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      due_rsp_q.push_back(apply_request(op, d));
      items_sent++;
      @(negedge clock);
   endtask

   // Range checks on every kind, unused fields and unknown kinds
   task automatic test_entry_ranges();
      send_request(OP_APPEND, entry_word(KIND_STARTUP, 6'd63, 5'd31, 6'd63, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_EVERY_MIN, 6'd1, 5'd31, 6'd63, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_EVERY_MIN, 6'd59, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_EVERY_MIN, 6'd0, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_EVERY_MIN, 6'd60, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_EVERY_HOUR, 6'd23, 5'd31, 6'd63, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_EVERY_HOUR, 6'd24, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_EVERY_HOUR, 6'd1, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_DAILY, 6'd63, 5'd23, 6'd59, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_DAILY, 6'd0, 5'd24, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_DAILY, 6'd0, 5'd0, 6'd60, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_WEEKLY, 6'd63, 5'd23, 6'd59, 3'd6));
      send_request(OP_APPEND, entry_word(KIND_WEEKLY, 6'd0, 5'd0, 6'd0, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_WEEKLY, 6'd0, 5'd0, 6'd0, 3'd0));
      for (int k = 5; k < 8; k++)
         send_request(OP_APPEND, entry_word(3'(k), 6'd1, 5'd0, 6'd0, 3'd0));
   endtask

   // Startup, matching ticks, served minute, out of range clock and clear
   task automatic test_clock_match();
      send_request(OP_STARTUP, clock_word(6'd0, 5'd0, 3'd0));
      send_request(OP_TICK, clock_word(6'd0, 5'd0, 3'd0));
      send_request(OP_TICK, clock_word(6'd0, 5'd5, 3'd3));
      send_request(OP_TICK, clock_word(6'd59, 5'd23, 3'd6));
      send_request(OP_TICK, clock_word(6'd30, 5'd6, 3'd0));
      send_request(OP_TICK, clock_word(6'd63, 5'd31, 3'd7));
      send_request(OP_TICK, clock_word(6'd0, 5'd23, 3'd0));
      send_request(OP_CLEAR, clock_word(6'd0, 5'd0, 3'd0));
      send_request(OP_TICK, clock_word(6'd0, 5'd1, 3'd1));
      send_request(OP_STARTUP, clock_word(6'd0, 5'd0, 3'd0));
      send_request(OP_TICK, clock_word(6'd1, 5'd0, 3'd0));
   endtask

   // Fill the table with periodic entries, then push past the end
   task automatic test_full_table();
      send_request(OP_CLEAR, clock_word(6'd0, 5'd0, 3'd0));
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
         if (i % 2 == 0)
            send_request(OP_APPEND, entry_word(KIND_EVERY_MIN, 6'(i % 59 + 1),
                                               5'd0, 6'd0, 3'd0));
         else
            send_request(OP_APPEND, entry_word(KIND_EVERY_HOUR, 6'(i % 23 + 1),
                                               5'd0, 6'd0, 3'd0));
      end
      send_request(OP_APPEND, entry_word(KIND_STARTUP, 6'd0, 5'd0, 6'd0, 3'd0));
      send_request(OP_APPEND, entry_word(KIND_WEEKLY, 6'd0, 5'd0, 6'd0, 3'd7));
      send_request(OP_APPEND, entry_word(KIND_DAILY, 6'd0, 5'd12, 6'd12, 3'd0));
      send_request(OP_STARTUP, clock_word(6'd0, 5'd0, 3'd0));
      send_request(OP_TICK, clock_word(6'd12, 5'd12, 3'd2));
      send_request(OP_TICK, clock_word(6'd0, 5'd12, 3'd2));
   endtask

   // At times clear, append a batch of entries, then walk the wall clock across them
   task automatic test_random_schedules(input int item_goal);
      req_data_type d;
      int           n_append;
      int           n_tick;
      int           r;
      while (items_sent < item_goal) begin
         if ($urandom_range(99) < 8) begin
            send_request(2'($urandom_range(3)), random_word());
         end else begin
            if ($urandom_range(99) < 30) send_request(OP_CLEAR, random_word());
            n_append = ($urandom_range(99) < 5) ? $urandom_range(28, 36)
                                                : $urandom_range(0, 8);
            repeat (n_append) begin
               d = random_word();
               if ($urandom_range(99) < 85) begin
                  d.entry_kind = 3'($urandom_range(4));
                  case (d.entry_kind)
                     KIND_EVERY_MIN:  d.entry_period = 6'($urandom_range(1, 59));
                     KIND_EVERY_HOUR: d.entry_period = 6'($urandom_range(1, 23));
                     KIND_DAILY, KIND_WEEKLY: begin
                        // aim half of them just ahead of the wall clock
                        if ($urandom_range(1) == 1) begin
                           d.entry_minute  = 6'((wall_minute + $urandom_range(1, 8)) % 60);
                           d.entry_hour    = 5'(wall_hour);
                           d.entry_weekday = 3'(wall_wday);
                        end else begin
                           d.entry_minute  = 6'($urandom_range(59));
                           d.entry_hour    = 5'($urandom_range(23));
                           d.entry_weekday = 3'($urandom_range(6));
                        end
                     end
                     default: ;
                  endcase
               end
               send_request(OP_APPEND, d);
            end
            n_tick = $urandom_range(3, 20);
            repeat (n_tick) begin
               d = random_word();
               if ($urandom_range(99) < 10) begin
                  send_request(OP_STARTUP, d);
               end else begin
                  // step a minute, jump, or repeat the minute already served
                  r = $urandom_range(99);
                  if (r < 75) begin
                     wall_minute++;
                     if (wall_minute == 60) begin
                        wall_minute = 0;
                        wall_hour++;
                        if (wall_hour == 24) begin
                           wall_hour = 0;
                           wall_wday = (wall_wday + 1) % 7;
                        end
                     end
                  end else if (r < 90) begin
                     wall_minute = ($urandom_range(1) == 1) ? 0 : $urandom_range(59);
                     wall_hour   = $urandom_range(23);
                     wall_wday   = $urandom_range(6);
                  end
                  d.now_minute  = 6'(wall_minute);
                  d.now_hour    = 5'(wall_hour);
                  d.now_weekday = 3'(wall_wday);
                  send_request(OP_TICK, d);
               end
            end
         end
      end
   endtask

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each response word with the oldest prediction
   always @(posedge clock) begin
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (due_rsp_q.size() == 0) begin
            $display("%0t: unexpected response word %h", $time, got);
            fail_count++;
         end else begin
            want = due_rsp_q.pop_front();
            if (got.due_mask !== want.due_mask) begin
               $display("%0t: due_mask expected %h actual %h", $time,
                        want.due_mask, got.due_mask);
               fail_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, got.status);
               fail_count++;
            end
            if (got.job_count !== want.job_count) begin
               $display("%0t: job_count expected %0d actual %0d", $time,
                        want.job_count, got.job_count);
               fail_count++;
            end
         end
      end
   end

   // End the run when neither side moves a word for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("schedule_match_table_top regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_entry_ranges();
      test_clock_match();
      test_full_table();
      test_random_schedules(550);

      send_idle_pct = 87;
      recv_idle_pct = 17;
      test_random_schedules(1100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_schedules(1650);

      // drain outstanding responses, then watch for strays
      req_tvalid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("schedule_match_table_top regression: pass");
      else
         $display("schedule_match_table_top regression: fail");
      $finish;
   end

endmodule

[sim.f]
hdl/smt_pkg.sv
hdl/schedule_match_table_top.sv
dv/tb_schedule_match_table_top.sv
